[hw/rtl/c_keyword_count_lexer_macros.svh]
// Assertion macros shared by the keyword counter RTL.
`ifndef C_KEYWORD_COUNT_LEXER_MACROS_SVH
`define C_KEYWORD_COUNT_LEXER_MACROS_SVH

// Same-cycle check, off while reset is held.
`define KCL_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Next-cycle check: when trig holds, cons must hold at the next clock.
`define KCL_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/kcl_pkg.sv]
// Shared types, constants and keyword table for the keyword counter.
package kcl_pkg;

    localparam int NUM_KEYWORDS    = 11;
    localparam int MAX_WORD_DEF    = 100;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int CHAR_W      = 8;
    localparam int IDENT_LEN_W = 7;
    localparam int KW_IDX_W    = 4;
    localparam int OUT_COUNT_W = 16;
    localparam int KW_TEXT_W   = 64;

    // Opcodes of an input request
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters that steer the lexical mode
    localparam logic [CHAR_W-1:0] CH_SLASH      = 8'h2f;
    localparam logic [CHAR_W-1:0] CH_STAR       = 8'h2a;
    localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
    localparam logic [CHAR_W-1:0] CH_QUOTE      = 8'h22;
    localparam logic [CHAR_W-1:0] CH_APOS       = 8'h27;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0a;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5f;

    // Keyword table, alphabetical; text left aligned, first char in the top byte
    localparam logic [KW_TEXT_W-1:0] KW_TEXT [NUM_KEYWORDS] = '{
        {"auto",     32'h0},
        {"break",    24'h0},
        {"case",     32'h0},
        {"char",     32'h0},
        {"const",    24'h0},
        {"continue"       },
        {"default",   8'h0},
        {"unsigned"       },
        {"void",     32'h0},
        {"volatile"       },
        {"while",    24'h0}
    };

    localparam logic [IDENT_LEN_W-1:0] KW_LEN [NUM_KEYWORDS] = '{
        7'd4, 7'd5, 7'd4, 7'd4, 7'd5, 7'd8, 7'd7, 7'd8, 7'd4, 7'd8, 7'd5
    };

    // Work item handed from the lexer to the counter bank
    typedef struct packed {
        logic                    report;
        logic [NUM_KEYWORDS-1:0] hit;
    } t_kcl_event;

    function automatic logic is_letter(input logic [CHAR_W-1:0] b);
        return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] b);
        return (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic is_word_char(input logic [CHAR_W-1:0] b);
        return is_letter(b) || is_digit(b) || (b == CH_UNDERSCORE);
    endfunction

    // Space, tab, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [CHAR_W-1:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0b) ||
               (b == 8'h0c) || (b == 8'h0d);
    endfunction

    // Keywords whose character at position pos equals b
    function automatic logic [NUM_KEYWORDS-1:0] kw_match(
        input logic [IDENT_LEN_W-1:0] pos,
        input logic [CHAR_W-1:0]      b
    );
        logic [NUM_KEYWORDS-1:0] m;
        logic [2:0]              sel;
        sel = pos[2:0];
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            m[k] = (pos < KW_LEN[k]) &&
                   (KW_TEXT[k][{3'(3'd7 - sel), 3'b000} +: CHAR_W] == b);
        end
        return m;
    endfunction

    // Candidates that are complete at length len
    function automatic logic [NUM_KEYWORDS-1:0] kw_hit(
        input logic [NUM_KEYWORDS-1:0] mask,
        input logic [IDENT_LEN_W-1:0]  len
    );
        logic [NUM_KEYWORDS-1:0] h;
        for (int k = 0; k < NUM_KEYWORDS; k++) begin
            h[k] = mask[k] && (KW_LEN[k] == len);
        end
        return h;
    endfunction

endpackage

[hw/rtl/kcl_front.sv]
// Lexer front end: tokenizes bytes, tracks mode, emits keyword hits and reports.
module kcl_front #(
    parameter int MAX_WORD = kcl_pkg::MAX_WORD_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_opcode,
    input  logic [kcl_pkg::CHAR_W-1:0]       i_source_byte,
    input  logic                             i_queue_full,
    output logic                             o_push,
    output kcl_pkg::t_kcl_event              o_event
);
    import kcl_pkg::*;

    typedef enum logic [3:0] {
        MODE_CODE    = 4'b0001,
        MODE_COMMENT = 4'b0010,
        MODE_PREPROC = 4'b0100,
        MODE_STRING  = 4'b1000
    } t_lex_mode;

    localparam logic [NUM_KEYWORDS-1:0] ALL_KW   = '1;
    localparam logic [IDENT_LEN_W-1:0]  LEN_STOP = IDENT_LEN_W'(MAX_WORD - 1);

    t_lex_mode               r_mode,     n_mode;
    logic [CHAR_W-1:0]       r_prev,     n_prev;
    logic                    r_in_ident, n_in_ident;
    logic [IDENT_LEN_W-1:0]  r_len,      n_len;
    logic                    r_alpha,    n_alpha;
    logic [NUM_KEYWORDS-1:0] r_mask,     n_mask;

    logic                    accept;
    logic                    count_ok;
    logic [NUM_KEYWORDS-1:0] app_mask;
    logic [IDENT_LEN_W-1:0]  app_len;
    logic [NUM_KEYWORDS-1:0] hit;
    logic                    report;

    assign accept   = i_in_valid && !i_queue_full;
    assign count_ok = r_in_ident && r_alpha && (r_mode == MODE_CODE);
    assign app_mask = r_mask & kw_match(r_len, i_source_byte);
    assign app_len  = r_len + 1'b1;

    always_comb begin
        n_mode     = r_mode;
        n_prev     = r_prev;
        n_in_ident = r_in_ident;
        n_len      = r_len;
        n_alpha    = r_alpha;
        n_mask     = r_mask;
        hit        = '0;
        report     = 1'b0;

        if (i_opcode == OP_END) begin
            // close pending word, then report
            report = 1'b1;
            if (count_ok) begin
                hit = kw_hit(r_mask, r_len);
            end
            n_in_ident = 1'b0;
            n_len      = '0;
            n_alpha    = 1'b0;
            n_mask     = ALL_KW;
        end else if (r_in_ident && is_word_char(i_source_byte)) begin
            if (app_len >= LEN_STOP) begin
                // split an over-long word
                if (count_ok) begin
                    hit = kw_hit(app_mask, app_len);
                end
                n_in_ident = 1'b0;
                n_len      = '0;
                n_alpha    = 1'b0;
                n_mask     = ALL_KW;
            end else begin
                n_mask = app_mask;
                n_len  = app_len;
            end
        end else begin
            if (r_in_ident) begin
                if (count_ok) begin
                    hit = kw_hit(r_mask, r_len);
                end
                n_in_ident = 1'b0;
                n_len      = '0;
                n_alpha    = 1'b0;
                n_mask     = ALL_KW;
            end
            if (is_blank(i_source_byte)) begin
                // skip white space other than newline
            end else if (is_letter(i_source_byte) || i_source_byte == CH_UNDERSCORE) begin
                n_in_ident = 1'b1;
                n_alpha    = is_letter(i_source_byte);
                n_prev     = i_source_byte;
                n_mask     = kw_match('0, i_source_byte);
                n_len      = IDENT_LEN_W'(1);
            end else begin
                n_prev = i_source_byte;
                case (r_mode)
                    MODE_CODE: begin
                        if (i_source_byte == CH_STAR && r_prev == CH_SLASH) begin
                            n_mode = MODE_COMMENT;
                        end else if (i_source_byte == CH_HASH) begin
                            n_mode = MODE_PREPROC;
                        end else if (i_source_byte == CH_QUOTE && r_prev != CH_APOS) begin
                            n_mode = MODE_STRING;
                        end
                    end
                    MODE_COMMENT: begin
                        if (i_source_byte == CH_SLASH && r_prev == CH_STAR) begin
                            n_mode = MODE_CODE;
                        end
                    end
                    MODE_PREPROC: begin
                        if (i_source_byte == CH_NEWLINE) begin
                            n_mode = MODE_CODE;
                        end
                    end
                    MODE_STRING: begin
                        if (i_source_byte == CH_QUOTE) begin
                            n_mode = MODE_CODE;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_CODE;
            r_prev     <= '0;
            r_in_ident <= 1'b0;
            r_len      <= '0;
            r_alpha    <= 1'b0;
            r_mask     <= ALL_KW;
        end else if (accept) begin
            r_mode     <= n_mode;
            r_prev     <= n_prev;
            r_in_ident <= n_in_ident;
            r_len      <= n_len;
            r_alpha    <= n_alpha;
            r_mask     <= n_mask;
        end
    end

    assign o_push         = accept && (report || (|hit));
    assign o_event.report = report;
    assign o_event.hit    = hit;

endmodule

[hw/rtl/kcl_queue.sv]
// Short request queue between the lexer and the counter bank.
`include "c_keyword_count_lexer_macros.svh"

module kcl_queue #(
    parameter int DEPTH = kcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kcl_pkg::t_kcl_event i_data,
    output logic                o_full,
    input  logic                i_pop,
    output kcl_pkg::t_kcl_event o_data,
    output logic                o_empty
);
    import kcl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_kcl_event       r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count,  n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    `KCL_ASSERT(a_no_overflow, i_push |-> !o_full, "request pushed into full queue")
    `KCL_ASSERT(a_no_underflow, i_pop |-> !o_empty, "request popped from empty queue")
    `KCL_ASSERT(a_ptr_agree, (o_empty || o_full) |-> (r_wr_ptr == r_rd_ptr), "queue pointers out of step")

endmodule

[hw/rtl/kcl_back.sv]
// Counter bank: applies keyword hits and streams the count report.
`include "c_keyword_count_lexer_macros.svh"

module kcl_back #(
    parameter int COUNT_WIDTH = kcl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_empty,
    input  kcl_pkg::t_kcl_event                i_event,
    output logic                               o_pop,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [kcl_pkg::KW_IDX_W-1:0]       o_keyword_index,
    output logic [kcl_pkg::OUT_COUNT_W-1:0]    o_keyword_count,
    output logic                               o_last_of_report
);
    import kcl_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } t_back_state;

    localparam logic [KW_IDX_W-1:0] LAST_IDX = KW_IDX_W'(NUM_KEYWORDS - 1);

    t_back_state           r_state;
    logic [COUNT_WIDTH-1:0] r_counts [NUM_KEYWORDS];
    logic [KW_IDX_W-1:0]   r_rep_idx;
    logic                  r_out_valid;
    logic [KW_IDX_W-1:0]   r_out_idx;
    logic [OUT_COUNT_W-1:0] r_out_count;
    logic                  r_out_last;

    logic out_free;
    logic pop;
    logic load;
    logic rep_last;

    assign out_free = !r_out_valid || !i_out_stall;
    assign pop      = (r_state == ST_IDLE) && !i_empty;
    assign load     = (r_state == ST_REPORT) && out_free;
    assign rep_last = (r_rep_idx == LAST_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rep_idx   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < NUM_KEYWORDS; k++) begin
                r_counts[k] <= '0;
            end
        end else begin
            if (pop) begin
                for (int k = 0; k < NUM_KEYWORDS; k++) begin
                    if (i_event.hit[k] && r_counts[k] != '1) begin
                        r_counts[k] <= r_counts[k] + 1'b1;
                    end
                end
                if (i_event.report) begin
                    r_state   <= ST_REPORT;
                    r_rep_idx <= '0;
                end
            end
            if (load) begin
                r_out_valid <= 1'b1;
                if (rep_last) begin
                    r_state <= ST_IDLE;
                end else begin
                    r_rep_idx <= r_rep_idx + 1'b1;
                end
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_idx   <= r_rep_idx;
            r_out_count <= OUT_COUNT_W'(r_counts[r_rep_idx]);
            r_out_last  <= rep_last;
        end
    end

    assign o_pop            = pop;
    assign o_out_valid      = r_out_valid;
    assign o_keyword_index  = r_out_idx;
    assign o_keyword_count  = r_out_count;
    assign o_last_of_report = r_out_last;

    `KCL_ASSERT(a_idx_range, (r_state == ST_REPORT) |-> (r_rep_idx <= LAST_IDX), "report index past table end")
    `KCL_ASSERT(a_last_tag, r_out_valid |-> (r_out_last == (r_out_idx == LAST_IDX)), "last flag on wrong entry")
    `KCL_ASSERT_NEXT(a_idx_step, r_out_valid && !i_out_stall && !r_out_last, !r_out_valid || (r_out_idx == $past(r_out_idx) + 1'b1), "report entries out of order")

endmodule

[hw/rtl/c_keyword_count_lexer.sv]
// Top level of the C keyword counter: lexer, request queue and counter bank.
//
// Feed C source one byte per request (opcode 0); the block takes one byte every clock
// while its request queue has room. Bytes are split into identifiers and single-character
// tokens, the lexical mode (code, block comment, preprocessor line, string) follows the
// token pairs, and each identifier closed in code mode that spells one of the eleven table
// keywords bumps a saturating counter. An end-of-input request (opcode 1) closes any
// pending identifier and makes the block stream eleven result requests, one per keyword in
// table order, zero counts included, with last_of_report set on the final one. Counts are
// kept across reports. Rate: one input byte per cycle while the queue has room; a report
// holds the output port, one entry per cycle with no output stall, and while it drains the
// lexer keeps taking bytes until QUEUE_DEPTH further identifier hits or reports are waiting.
// An end-of-input request passes through the request queue and the report state before its
// first entry is loaded into the output register. There is no clearing pass after reset.

module c_keyword_count_lexer #(
    parameter int MAX_WORD    = kcl_pkg::MAX_WORD_DEF,
    parameter int COUNT_WIDTH = kcl_pkg::COUNT_WIDTH_DEF,
    parameter int QUEUE_DEPTH = kcl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // source byte requests
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_opcode,
    input  logic [kcl_pkg::CHAR_W-1:0]      i_source_byte,
    // count report requests
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [kcl_pkg::KW_IDX_W-1:0]    o_keyword_index,
    output logic [kcl_pkg::OUT_COUNT_W-1:0] o_keyword_count,
    output logic                            o_last_of_report
);
    import kcl_pkg::*;

    t_kcl_event push_event;
    t_kcl_event pop_event;
    logic       push;
    logic       pop;
    logic       queue_full;
    logic       queue_empty;

    // Stall the source whenever the queue is full, whatever the byte would do.
    assign o_in_stall = queue_full;

    // Front: tokenize and classify; push only requests that touch the counters.
    kcl_front #(
        .MAX_WORD (MAX_WORD)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_opcode      (i_opcode),
        .i_source_byte (i_source_byte),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_event       (push_event)
    );

    // Queue: decouple the byte stream from report drain and output stalls.
    kcl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_event),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_data  (pop_event),
        .o_empty (queue_empty)
    );

    // Back: apply hits to the counters and stream reports through an output register.
    kcl_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_empty          (queue_empty),
        .i_event          (pop_event),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_keyword_index  (o_keyword_index),
        .o_keyword_count  (o_keyword_count),
        .o_last_of_report (o_last_of_report)
    );

endmodule
